/* rtl/pcbc_pkg.sv */
package pcbc_pkg;

  localparam int COORD_BITS     = 32;
  localparam int POINTS_SEEN_W  = 17;
  localparam int DEF_MAX_POINTS = 65536;
  localparam int AXES           = 3;

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] centroid_x;
    logic signed [COORD_BITS-1:0] centroid_y;
    logic signed [COORD_BITS-1:0] centroid_z;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic [POINTS_SEEN_W-1:0]     points_seen;
    logic                         count_overflow;
  } result_t;

endpackage

/* rtl/point_cloud_bounds_centroid.sv */
// Streams 3-D points (signed Q16.16) and gives, on the point marked last_point, one result:
// the axis-aligned bounding box, the centroid (sum / count per axis, truncated toward zero),
// the saturated point count and an overflow flag; running state then clears for the next
// cloud. Points past MAX_POINTS widen the box but do not enter the sums or the count.
// A point that is not last is taken in IDLE and then goes one axis at a time through a
// single shared compare/add unit in ACC. A last point adds the centroid division, done by one
// shared restoring divider for all three axes, each axis in DIV_LOAD, DIV_RUN and DIV_END;
// the result register is then loaded in SEND, which waits while an older result is held.
// point_ready stays low until the point's work is done; a finished result may wait in
// its register while the next cloud's points stream in.
module point_cloud_bounds_centroid #(
  parameter int MAX_POINTS = pcbc_pkg::DEF_MAX_POINTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_ready,
  input  pcbc_pkg::point_t  point,
  output logic              result_valid,
  input  logic              result_ready,
  output pcbc_pkg::result_t result
);

  localparam int CB     = pcbc_pkg::COORD_BITS;
  localparam int PSW    = pcbc_pkg::POINTS_SEEN_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = CB + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    IDLE, ACC, DIV_LOAD, DIV_RUN, DIV_END, SEND
  } state_t;

  state_t state;

  pcbc_pkg::point_t pt;
  logic [1:0] axis;

  logic signed [CB-1:0] run_min [pcbc_pkg::AXES];
  logic signed [CB-1:0] run_max [pcbc_pkg::AXES];
  logic [SUM_W-1:0]     sum     [pcbc_pkg::AXES];
  logic signed [CB-1:0] cen     [pcbc_pkg::AXES];
  logic [CNT_W-1:0]     point_count;
  logic                 overflow_seen;

  // divider registers
  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [STEP_W-1:0] step;
  logic              neg;

  logic signed [CB-1:0] c;
  logic [SUM_W-1:0]     c_ext;
  logic                 below_max;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_diff;
  logic                 fits;
  logic [SUM_W-1:0]     sum_sel;
  logic [CB-1:0]        q_lo;
  logic [CNT_W+PSW-1:0] cnt_ext;

  always_comb begin
    case (axis)
      2'd0:    c = pt.coord_x;
      2'd1:    c = pt.coord_y;
      default: c = pt.coord_z;
    endcase
    c_ext     = {{(SUM_W-CB){c[CB-1]}}, c};
    below_max = point_count < CNT_W'(MAX_POINTS);
    sum_sel   = sum[axis];
    rem_sh    = {rem[CNT_W-1:0], quo[SUM_W-1]};
    rem_diff  = rem_sh - {1'b0, point_count};
    fits      = rem_sh >= {1'b0, point_count};
    q_lo      = quo[CB-1:0];
    cnt_ext   = {{PSW{1'b0}}, point_count};
  end

  assign point_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      result_valid  <= 1'b0;
      axis          <= '0;
      point_count   <= '0;
      overflow_seen <= 1'b0;
      for (int i = 0; i < pcbc_pkg::AXES; i++) begin
        run_min[i] <= pcbc_pkg::COORD_MAX;
        run_max[i] <= pcbc_pkg::COORD_MIN;
        sum[i]     <= '0;
      end
    end else begin
      // in SEND the result register reloads on a transfer instead
      if (result_valid && result_ready && state != SEND) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (point_valid) begin
            pt    <= point;
            axis  <= '0;
            state <= ACC;
          end
        end
        ACC: begin
          if (c < run_min[axis]) run_min[axis] <= c;
          if (c > run_max[axis]) run_max[axis] <= c;
          if (below_max) sum[axis] <= sum[axis] + c_ext;
          if (axis == 2'(pcbc_pkg::AXES - 1)) begin
            if (below_max) begin
              point_count <= point_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            axis  <= '0;
            state <= pt.last_point ? DIV_LOAD : IDLE;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        DIV_LOAD: begin
          neg   <= sum_sel[SUM_W-1];
          quo   <= sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
          rem   <= '0;
          step  <= '0;
          state <= DIV_RUN;
        end
        DIV_RUN: begin
          // one restoring step per cycle, quotient bits shift in from the right
          quo <= {quo[SUM_W-2:0], fits};
          rem <= fits ? rem_diff : rem_sh;
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= DIV_END;
          end else begin
            step <= step + 1'b1;
          end
        end
        DIV_END: begin
          cen[axis] <= neg ? -q_lo : q_lo;
          if (axis == 2'(pcbc_pkg::AXES - 1)) begin
            state <= SEND;
          end else begin
            axis  <= axis + 1'b1;
            state <= DIV_LOAD;
          end
        end
        SEND: begin
          if (!result_valid || result_ready) begin
            result.centroid_x     <= cen[0];
            result.centroid_y     <= cen[1];
            result.centroid_z     <= cen[2];
            result.box_min_x      <= run_min[0];
            result.box_min_y      <= run_min[1];
            result.box_min_z      <= run_min[2];
            result.box_max_x      <= run_max[0];
            result.box_max_y      <= run_max[1];
            result.box_max_z      <= run_max[2];
            result.points_seen    <= cnt_ext[PSW-1:0];
            result.count_overflow <= overflow_seen;
            result_valid          <= 1'b1;
            // start the next cloud
            point_count   <= '0;
            overflow_seen <= 1'b0;
            for (int i = 0; i < pcbc_pkg::AXES; i++) begin
              run_min[i] <= pcbc_pkg::COORD_MAX;
              run_max[i] <= pcbc_pkg::COORD_MIN;
              sum[i]     <= '0;
            end
            axis  <= '0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
